// File: hw/rtl/rdi_pkg.sv
package rdi_pkg;

    localparam int ANGLE_STEPS = 16;
    localparam int T_STEPS     = 49;
    localparam int SQRT_STEPS  = 31;
    localparam int UV_STEPS    = 17;
    localparam int MID_STAGES  = (SQRT_STEPS > ANGLE_STEPS) ? SQRT_STEPS : ANGLE_STEPS;

    localparam int DEG_HALF    = 11796480;
    localparam int DEG_FULL    = 23592960;
    localparam int DEG_QUARTER = DEG_HALF / 2;
    localparam int DEG_3Q      = DEG_HALF + DEG_HALF / 2;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [24:0] SWEEP_RESET  = 25'd23592960;

    // atan(2^-i) in degrees, Q16.16
    localparam logic [21:0] ATAN_DEG [32] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117266,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef enum logic [1:0] {
        CFG_PLANE_HEIGHT  = 2'd0,
        CFG_DISK_RADIUS   = 2'd1,
        CFG_SWEEP_DEGREES = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] plane_height;
        logic [30:0]        disk_radius;
        logic [24:0]        sweep_degrees;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_lower;
        logic signed [31:0] t_upper;
    } t_ray;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [61:0]        r2;
    } t_hit;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
    } t_result;

endpackage

// File: hw/rtl/rdi_locate.sv
module rdi_locate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  rdi_pkg::t_cfg i_cfg,
    input  rdi_pkg::t_ray i_ray,
    output rdi_pkg::t_hit o_hit
);
    import rdi_pkg::*;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic               neg;
        logic [31:0]        den;
        logic [31:0]        rem;
        logic [48:0]        qd;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] tlo;
        logic signed [31:0] thi;
    } t_tdiv;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } t_tst;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [63:0] px;
        logic signed [63:0] py;
    } t_mul;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_xy;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [61:0]        sqx;
        logic [61:0]        sqy;
    } t_sq;

    t_tdiv r_div [T_STEPS+1];
    t_tdiv n_div0;
    t_tst  r_t, n_t;
    t_mul  r_mul, n_mul;
    t_xy   r_xy, n_xy;
    t_sq   r_sq, n_sq;
    t_hit  r_r2, n_r2;
    logic [61:0] r_rad_sq;

    logic signed [32:0] w_diff;
    logic signed [48:0] w_num;
    logic [49:0]        w_mag;
    logic signed [49:0] w_ts;
    logic signed [49:0] w_lo;
    logic signed [49:0] w_hi;
    logic signed [48:0] w_x;
    logic signed [48:0] w_y;
    logic signed [48:0] w_rad;
    logic signed [63:0] w_sqx;
    logic signed [63:0] w_sqy;
    logic [62:0]        w_r2;

    always_ff @(posedge i_clk) begin
        r_rad_sq <= i_cfg.disk_radius * i_cfg.disk_radius;
    end

    // setup of the t division
    always_comb begin
        w_diff = {i_cfg.plane_height[31], i_cfg.plane_height}
               - {i_ray.origin_z[31], i_ray.origin_z};
        w_num  = {w_diff, 16'd0};
        n_div0.valid = i_ray.valid;
        n_div0.miss  = (i_cfg.sweep_degrees == '0) || (i_cfg.disk_radius == '0)
                     || (i_ray.dir_z == '0);
        n_div0.neg   = w_num[48] ^ i_ray.dir_z[31];
        n_div0.den   = i_ray.dir_z[31] ? (~i_ray.dir_z + 32'd1) : i_ray.dir_z;
        n_div0.rem   = '0;
        n_div0.qd    = w_num[48] ? (~w_num + 49'd1) : w_num;
        n_div0.ox    = i_ray.origin_x;
        n_div0.oy    = i_ray.origin_y;
        n_div0.dx    = i_ray.dir_x;
        n_div0.dy    = i_ray.dir_y;
        n_div0.tlo   = i_ray.t_lower;
        n_div0.thi   = i_ray.t_upper;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].valid <= 1'b0;
        end else if (i_en) begin
            r_div[0] <= n_div0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= T_STEPS; k++) begin : g_tdiv
        logic [32:0] w_sh;
        logic [32:0] w_sub;
        t_tdiv       n_st;

        always_comb begin
            w_sh  = {r_div[k-1].rem, r_div[k-1].qd[48]};
            w_sub = w_sh - {1'b0, r_div[k-1].den};
            n_st  = r_div[k-1];
            if (!w_sub[32]) begin
                n_st.rem = w_sub[31:0];
                n_st.qd  = {r_div[k-1].qd[47:0], 1'b1};
            end else begin
                n_st.rem = w_sh[31:0];
                n_st.qd  = {r_div[k-1].qd[47:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k].valid <= 1'b0;
            end else if (i_en) begin
                r_div[k] <= n_st;
            end
        end
    end

    // sign and interval test
    always_comb begin
        w_mag = {1'b0, r_div[T_STEPS].qd};
        w_ts  = r_div[T_STEPS].neg ? (~w_mag + 50'd1) : w_mag;
        w_lo  = {{18{r_div[T_STEPS].tlo[31]}}, r_div[T_STEPS].tlo};
        w_hi  = {{18{r_div[T_STEPS].thi[31]}}, r_div[T_STEPS].thi};
        n_t.valid = r_div[T_STEPS].valid;
        n_t.miss  = r_div[T_STEPS].miss || (w_ts < w_lo) || (w_ts > w_hi);
        n_t.t     = w_ts[31:0];
        n_t.ox    = r_div[T_STEPS].ox;
        n_t.oy    = r_div[T_STEPS].oy;
        n_t.dx    = r_div[T_STEPS].dx;
        n_t.dy    = r_div[T_STEPS].dy;
    end

    always_comb begin
        n_mul.valid = r_t.valid;
        n_mul.miss  = r_t.miss;
        n_mul.t     = r_t.t;
        n_mul.ox    = r_t.ox;
        n_mul.oy    = r_t.oy;
        n_mul.px    = r_t.dx * r_t.t;
        n_mul.py    = r_t.dy * r_t.t;
    end

    // hit point and box test
    always_comb begin
        w_x   = {{17{r_mul.ox[31]}}, r_mul.ox} + {r_mul.px[63], r_mul.px[63:16]};
        w_y   = {{17{r_mul.oy[31]}}, r_mul.oy} + {r_mul.py[63], r_mul.py[63:16]};
        w_rad = {18'd0, i_cfg.disk_radius};
        n_xy.valid = r_mul.valid;
        n_xy.miss  = r_mul.miss || (w_x > w_rad) || (w_x < -w_rad)
                   || (w_y > w_rad) || (w_y < -w_rad);
        n_xy.t     = r_mul.t;
        n_xy.x     = w_x[31:0];
        n_xy.y     = w_y[31:0];
    end

    always_comb begin
        w_sqx = r_xy.x * r_xy.x;
        w_sqy = r_xy.y * r_xy.y;
        n_sq.valid = r_xy.valid;
        n_sq.miss  = r_xy.miss;
        n_sq.t     = r_xy.t;
        n_sq.x     = r_xy.x;
        n_sq.y     = r_xy.y;
        n_sq.sqx   = w_sqx[61:0];
        n_sq.sqy   = w_sqy[61:0];
    end

    always_comb begin
        w_r2 = {1'b0, r_sq.sqx} + {1'b0, r_sq.sqy};
        n_r2.valid = r_sq.valid;
        n_r2.miss  = r_sq.miss || (w_r2 > {1'b0, r_rad_sq});
        n_r2.t     = r_sq.t;
        n_r2.x     = r_sq.x;
        n_r2.y     = r_sq.y;
        n_r2.r2    = w_r2[61:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t.valid   <= 1'b0;
            r_mul.valid <= 1'b0;
            r_xy.valid  <= 1'b0;
            r_sq.valid  <= 1'b0;
            r_r2.valid  <= 1'b0;
        end else if (i_en) begin
            r_t   <= n_t;
            r_mul <= n_mul;
            r_xy  <= n_xy;
            r_sq  <= n_sq;
            r_r2  <= n_r2;
        end
    end

    assign o_hit = r_r2;

endmodule

// File: hw/rtl/rdi_shade.sv
module rdi_shade (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  rdi_pkg::t_cfg    i_cfg,
    input  rdi_pkg::t_hit    i_hit,
    output rdi_pkg::t_result o_res
);
    import rdi_pkg::*;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [61:0]        r2sh;
        logic [32:0]        rem;
        logic [30:0]        root;
        logic signed [34:0] cx;
        logic signed [34:0] cy;
        logic signed [26:0] cz;
        logic               y0neg;
        logic               zero;
    } t_mid;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        root;
        logic [24:0]        theta;
    } t_ang;

    typedef struct packed {
        logic               valid;
        logic               miss;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [24:0]        rem_u;
        logic [16:0]        qd_u;
        logic [30:0]        rem_v;
        logic [16:0]        qd_v;
    } t_uv;

    t_mid r_mid [MID_STAGES+1];
    t_mid n_pre;
    t_ang r_ang, n_ang;
    t_uv  r_uv [UV_STEPS+1];
    t_uv  n_init;

    logic signed [34:0] w_xe;
    logic signed [34:0] w_ye;
    logic signed [26:0] w_zw;
    logic signed [26:0] w_cl;

    // half-plane fold and root setup
    always_comb begin
        w_xe = {{3{i_hit.x[31]}}, i_hit.x};
        w_ye = {{3{i_hit.y[31]}}, i_hit.y};
        n_pre.valid = i_hit.valid;
        n_pre.miss  = i_hit.miss;
        n_pre.t     = i_hit.t;
        n_pre.x     = i_hit.x;
        n_pre.y     = i_hit.y;
        n_pre.r2sh  = i_hit.r2;
        n_pre.rem   = '0;
        n_pre.root  = '0;
        n_pre.y0neg = i_hit.y[31];
        n_pre.zero  = (i_hit.x == '0) && (i_hit.y == '0);
        if (i_hit.x[31]) begin
            n_pre.cx = -w_xe;
            n_pre.cy = -w_ye;
            n_pre.cz = 27'(DEG_HALF);
        end else begin
            n_pre.cx = w_xe;
            n_pre.cy = w_ye;
            n_pre.cz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid[0].valid <= 1'b0;
        end else if (i_en) begin
            r_mid[0] <= n_pre;
        end
    end

    // square root digit and cordic rotation side by side
    for (genvar k = 1; k <= MID_STAGES; k++) begin : g_mid
        localparam logic signed [26:0] ATAN_K = 27'(ATAN_DEG[k-1]);
        logic [34:0]        w_sh;
        logic [35:0]        w_sub;
        logic signed [34:0] w_xs;
        logic signed [34:0] w_ys;
        t_mid               n_st;

        always_comb begin
            n_st  = r_mid[k-1];
            w_sh  = {r_mid[k-1].rem, r_mid[k-1].r2sh[61:60]};
            w_sub = {1'b0, w_sh} - {3'd0, r_mid[k-1].root, 2'b01};
            w_xs  = r_mid[k-1].cx >>> (k - 1);
            w_ys  = r_mid[k-1].cy >>> (k - 1);
            if (k <= SQRT_STEPS) begin
                n_st.r2sh = {r_mid[k-1].r2sh[59:0], 2'b00};
                if (!w_sub[35]) begin
                    n_st.rem  = w_sub[32:0];
                    n_st.root = {r_mid[k-1].root[29:0], 1'b1};
                end else begin
                    n_st.rem  = w_sh[32:0];
                    n_st.root = {r_mid[k-1].root[29:0], 1'b0};
                end
            end
            if (k <= ANGLE_STEPS) begin
                if (!r_mid[k-1].cy[34]) begin
                    n_st.cx = r_mid[k-1].cx + w_ys;
                    n_st.cy = r_mid[k-1].cy - w_xs;
                    n_st.cz = r_mid[k-1].cz + ATAN_K;
                end else begin
                    n_st.cx = r_mid[k-1].cx - w_ys;
                    n_st.cy = r_mid[k-1].cy + w_xs;
                    n_st.cz = r_mid[k-1].cz - ATAN_K;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mid[k].valid <= 1'b0;
            end else if (i_en) begin
                r_mid[k] <= n_st;
            end
        end
    end

    // wrap and clamp the angle to the half plane of the hit
    always_comb begin
        w_zw = r_mid[MID_STAGES].cz[26] ? (r_mid[MID_STAGES].cz + 27'(DEG_FULL))
                                        : r_mid[MID_STAGES].cz;
        w_cl = w_zw;
        if (!r_mid[MID_STAGES].y0neg) begin
            if (w_zw > 27'(DEG_HALF)) begin
                w_cl = (w_zw > 27'(DEG_3Q)) ? '0 : 27'(DEG_HALF);
            end
        end else begin
            if (w_zw < 27'(DEG_HALF)) begin
                w_cl = (w_zw < 27'(DEG_QUARTER)) ? 27'(DEG_FULL - 1) : 27'(DEG_HALF);
            end else if (w_zw > 27'(DEG_FULL - 1)) begin
                w_cl = 27'(DEG_FULL - 1);
            end
        end
        n_ang.valid = r_mid[MID_STAGES].valid;
        n_ang.miss  = r_mid[MID_STAGES].miss;
        n_ang.t     = r_mid[MID_STAGES].t;
        n_ang.x     = r_mid[MID_STAGES].x;
        n_ang.y     = r_mid[MID_STAGES].y;
        n_ang.root  = r_mid[MID_STAGES].root;
        n_ang.theta = r_mid[MID_STAGES].zero ? '0 : w_cl[24:0];
    end

    // sweep test; both quotients are at most one, so the division starts at bit 16
    always_comb begin
        n_init.valid = r_ang.valid;
        n_init.miss  = r_ang.miss || (r_ang.theta > i_cfg.sweep_degrees);
        n_init.t     = r_ang.t;
        n_init.x     = r_ang.x;
        n_init.y     = r_ang.y;
        n_init.rem_u = {1'b0, r_ang.theta[24:1]};
        n_init.qd_u  = {r_ang.theta[0], 16'd0};
        n_init.rem_v = {1'b0, r_ang.root[30:1]};
        n_init.qd_v  = {r_ang.root[0], 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang.valid   <= 1'b0;
            r_uv[0].valid <= 1'b0;
        end else if (i_en) begin
            r_ang   <= n_ang;
            r_uv[0] <= n_init;
        end
    end

    for (genvar k = 1; k <= UV_STEPS; k++) begin : g_uv
        logic [25:0] w_shu;
        logic [26:0] w_subu;
        logic [31:0] w_shv;
        logic [32:0] w_subv;
        t_uv         n_st;

        always_comb begin
            n_st   = r_uv[k-1];
            w_shu  = {r_uv[k-1].rem_u, r_uv[k-1].qd_u[16]};
            w_subu = {1'b0, w_shu} - {2'd0, i_cfg.sweep_degrees};
            w_shv  = {r_uv[k-1].rem_v, r_uv[k-1].qd_v[16]};
            w_subv = {1'b0, w_shv} - {2'd0, i_cfg.disk_radius};
            if (!w_subu[26]) begin
                n_st.rem_u = w_subu[24:0];
                n_st.qd_u  = {r_uv[k-1].qd_u[15:0], 1'b1};
            end else begin
                n_st.rem_u = w_shu[24:0];
                n_st.qd_u  = {r_uv[k-1].qd_u[15:0], 1'b0};
            end
            if (!w_subv[32]) begin
                n_st.rem_v = w_subv[30:0];
                n_st.qd_v  = {r_uv[k-1].qd_v[15:0], 1'b1};
            end else begin
                n_st.rem_v = w_shv[30:0];
                n_st.qd_v  = {r_uv[k-1].qd_v[15:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_uv[k].valid <= 1'b0;
            end else if (i_en) begin
                r_uv[k] <= n_st;
            end
        end
    end

    always_comb begin
        o_res.valid = r_uv[UV_STEPS].valid;
        o_res.hit   = !r_uv[UV_STEPS].miss;
        o_res.t     = r_uv[UV_STEPS].t;
        o_res.x     = r_uv[UV_STEPS].x;
        o_res.y     = r_uv[UV_STEPS].y;
        o_res.u     = r_uv[UV_STEPS].qd_u;
        o_res.v     = r_uv[UV_STEPS].qd_v;
    end

endmodule

// File: hw/rtl/ray_disk_intersect.sv
// channel   direction  handshake                     payload
// ray       in         i_in_valid / o_in_stall       origin, direction, t interval
// hit       out        o_out_valid / i_out_stall     hit flag, t, x, y, u, v
// config    in         i_cfg_we                      i_cfg_index, i_cfg_data
//
// one ray per cycle unless the output stalls; rays pass the 49-step t divider,
// the 31-step square root and the 17-step u and v dividers in series
// synchronous active-low reset clears all stage valids and loads register defaults
// a stall on a valid output freezes every stage; no transaction is dropped or repeated
module ray_disk_intersect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_t_lower,
    input  logic signed [31:0] i_t_upper,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit_flag,
    output logic signed [31:0] o_hit_t,
    output logic signed [31:0] o_hit_x,
    output logic signed [31:0] o_hit_y,
    output logic [16:0]        o_coord_u,
    output logic [16:0]        o_coord_v,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rdi_pkg::*;

    t_cfg    r_cfg;
    t_ray    r_in;
    t_hit    w_hit;
    t_result w_res;
    t_result r_out;
    logic    w_en;

    assign w_en       = !r_out.valid || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_height  <= '0;
            r_cfg.disk_radius   <= RADIUS_RESET;
            r_cfg.sweep_degrees <= SWEEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PLANE_HEIGHT:  r_cfg.plane_height  <= i_cfg_data;
                CFG_DISK_RADIUS:   r_cfg.disk_radius   <= i_cfg_data[30:0];
                CFG_SWEEP_DEGREES: r_cfg.sweep_degrees <= i_cfg_data[24:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid    <= i_in_valid;
            r_in.origin_x <= i_origin_x;
            r_in.origin_y <= i_origin_y;
            r_in.origin_z <= i_origin_z;
            r_in.dir_x    <= i_dir_x;
            r_in.dir_y    <= i_dir_y;
            r_in.dir_z    <= i_dir_z;
            r_in.t_lower  <= i_t_lower;
            r_in.t_upper  <= i_t_upper;
        end
    end

    rdi_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_ray   (r_in),
        .o_hit   (w_hit)
    );

    rdi_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_hit   (w_hit),
        .o_res   (w_res)
    );

    // a miss leaves every field but valid at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_en) begin
            r_out.valid <= w_res.valid;
            r_out.hit   <= w_res.hit;
            r_out.t     <= w_res.hit ? w_res.t : '0;
            r_out.x     <= w_res.hit ? w_res.x : '0;
            r_out.y     <= w_res.hit ? w_res.y : '0;
            r_out.u     <= w_res.hit ? w_res.u : '0;
            r_out.v     <= w_res.hit ? w_res.v : '0;
        end
    end

    assign o_out_valid = r_out.valid;
    assign o_hit_flag  = r_out.hit;
    assign o_hit_t     = r_out.t;
    assign o_hit_x     = r_out.x;
    assign o_hit_y     = r_out.y;
    assign o_coord_u   = r_out.u;
    assign o_coord_v   = r_out.v;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rdi_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi;
    } t_ray_item;

    typedef struct {
        logic               hit;
        logic signed [31:0] t, x, y;
        logic [16:0]        u, v;
    } t_disk_hit;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic signed [31:0] i_t_lower = '0, i_t_upper = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_hit_flag;
    logic signed [31:0] o_hit_t, o_hit_x, o_hit_y;
    logic [16:0]        o_coord_u, o_coord_v;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_PLANE_HEIGHT;
    logic [31:0]        i_cfg_data = '0;

    ray_disk_intersect uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_ray_item ray_queue[$];
    t_disk_hit hit_expect[$];
    int        failures = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        ray_taken = 1'b0;

    longint    cur_height = 0;
    longint    cur_radius = 65536;
    longint    cur_sweep = DEG_FULL;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res, bit_v;
        res = 0;
        bit_v = 64'sd1 <<< 62;
        while (bit_v > n) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic longint hit_angle(longint x0, longint y0);
        longint x, y, z, xs, ys;
        x = x0;
        y = y0;
        z = 0;
        if (x0 == 0 && y0 == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = DEG_HALF;
        end
        for (int i = 0; i < ANGLE_STEPS && i < 32; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_DEG[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_DEG[i]);
            end
        end
        if (z < 0) z = z + DEG_FULL;
        if (y0 >= 0) begin
            if (z > DEG_HALF) z = (z > DEG_3Q) ? 0 : DEG_HALF;
        end else begin
            if (z < DEG_HALF) z = (z < DEG_QUARTER) ? DEG_FULL - 1 : DEG_HALF;
            if (z > DEG_FULL - 1) z = DEG_FULL - 1;
        end
        return z;
    endfunction

    function automatic t_disk_hit predict_hit(t_ray_item r);
        t_disk_hit h;
        longint t, x, y, r2, theta, u, v;
        h = '{hit: 1'b0, t: '0, x: '0, y: '0, u: '0, v: '0};
        if (cur_sweep == 0 || cur_radius == 0 || r.dz == 0) return h;
        t = ((cur_height - longint'(r.oz)) * 65536) / longint'(r.dz);
        if (t < longint'(r.tlo) || t > longint'(r.thi)) return h;
        x = longint'(r.ox) + ((longint'(r.dx) * t) >>> 16);
        y = longint'(r.oy) + ((longint'(r.dy) * t) >>> 16);
        if (x > cur_radius || x < -cur_radius || y > cur_radius || y < -cur_radius) return h;
        r2 = x * x + y * y;
        if (r2 > cur_radius * cur_radius) return h;
        theta = hit_angle(x, y);
        if (theta > cur_sweep) return h;
        v = (int_sqrt(r2) * 65536) / cur_radius;
        if (v > 65536) v = 65536;
        u = (theta * 65536) / cur_sweep;
        if (u > 65536) u = 65536;
        h.hit = 1'b1;
        h.t = t[31:0];
        h.x = x[31:0];
        h.y = y[31:0];
        h.u = u[16:0];
        h.v = v[16:0];
        return h;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || ray_taken) begin
                if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_ray_item r;
                    r = ray_queue.pop_front();
                    i_origin_x <= r.ox;
                    i_origin_y <= r.oy;
                    i_origin_z <= r.oz;
                    i_dir_x <= r.dx;
                    i_dir_y <= r.dy;
                    i_dir_z <= r.dz;
                    i_t_lower <= r.tlo;
                    i_t_upper <= r.thi;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_disk_intersect regression: fail");
            $finish;
        end
        ray_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PLANE_HEIGHT:  cur_height = longint'($signed(i_cfg_data));
                    CFG_DISK_RADIUS:   cur_radius = longint'(i_cfg_data[30:0]);
                    CFG_SWEEP_DEGREES: cur_sweep = longint'(i_cfg_data[24:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                t_ray_item r;
                r = '{i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z,
                      i_t_lower, i_t_upper};
                hit_expect.push_back(predict_hit(r));
                ray_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (hit_expect.size() == 0) begin
                    $error("unexpected transaction on output");
                    failures++;
                end else begin
                    t_disk_hit e;
                    e = hit_expect.pop_front();
                    if (o_hit_flag !== e.hit) begin
                        $error("hit_flag expected %0d got %0d", e.hit, o_hit_flag);
                        failures++;
                    end
                    if (o_hit_t !== e.t) begin
                        $error("hit_t expected %0d got %0d", e.t, o_hit_t);
                        failures++;
                    end
                    if (o_hit_x !== e.x) begin
                        $error("hit_x expected %0d got %0d", e.x, o_hit_x);
                        failures++;
                    end
                    if (o_hit_y !== e.y) begin
                        $error("hit_y expected %0d got %0d", e.y, o_hit_y);
                        failures++;
                    end
                    if (o_coord_u !== e.u) begin
                        $error("coord_u expected %0d got %0d", e.u, o_coord_u);
                        failures++;
                    end
                    if (o_coord_v !== e.v) begin
                        $error("coord_v expected %0d got %0d", e.v, o_coord_v);
                        failures++;
                    end
                end
            end
        end
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // uniform in [-lim, lim]
    function automatic longint rand_span(longint lim);
        longint raw;
        if (lim <= 0) return 0;
        raw = longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff);
        return raw % (2 * lim + 1) - lim;
    endfunction

    function automatic t_ray_item straight_ray(longint x, longint y);
        t_ray_item r;
        r = '{sat32(x), sat32(y), 32'sd65536, 32'sd0, 32'sd0, -32'sd65536,
              32'sd0, 32'sd131072};
        return r;
    endfunction

    function automatic t_ray_item random_ray();
        t_ray_item r;
        longint t, dx, dy, dz, hx, hy, lim;
        if ($urandom_range(99) < 10) begin
            r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom};
            return r;
        end
        case ($urandom_range(9))
            0: dz = 1;
            1: dz = rand_span(64'sd2147483647);
            default: dz = $urandom_range(1, 1 << 18);
        endcase
        if (dz == 0) dz = -1;
        if ($urandom_range(1)) dz = -dz;
        t = $urandom_range(0, 16 * 65536);
        lim = cur_radius + cur_radius / 4 + 2;
        hx = rand_span(lim);
        hy = rand_span(lim);
        if ($urandom_range(9) == 0) hy = 0;
        dx = rand_span(1 << 18);
        dy = rand_span(1 << 18);
        r.dx = sat32(dx);
        r.dy = sat32(dy);
        r.dz = sat32(dz);
        r.ox = sat32(hx - ((dx * t) >>> 16));
        r.oy = sat32(hy - ((dy * t) >>> 16));
        r.oz = sat32(cur_height - ((dz * t) >>> 16));
        if ($urandom_range(9) == 0) begin
            r.tlo = sat32(t + $urandom_range(1, 65536));
            r.thi = sat32(t);
        end else begin
            r.tlo = sat32(t - $urandom_range(0, 65536));
            r.thi = sat32(t + $urandom_range(0, 65536));
        end
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (ray_queue.size() != 0 || i_in_valid || hit_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    longint ph_tab[8] = '{0, 196608, -327680, 2147483647, -2147483648, 0, 65536, 0};
    longint rad_tab[8] = '{65536, 262144, 32768, 2147483647, 1, 0, 6553600, 131072};
    longint sw_tab[8] = '{DEG_FULL, DEG_HALF, DEG_QUARTER, 0, 33554431, DEG_FULL,
                          33554431, 1};
    int idle_tab[8] = '{0, 85, 0, 15, 0, 0, 15, 85};
    int stall_tab[8] = '{0, 0, 85, 15, 0, 85, 15, 0};
    int count_tab[8] = '{180, 200, 200, 100, 100, 100, 300, 150};

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                write_reg(CFG_PLANE_HEIGHT, ph_tab[p][31:0]);
                write_reg(CFG_DISK_RADIUS, rad_tab[p][31:0]);
                write_reg(CFG_SWEEP_DEGREES, sw_tab[p][31:0]);
                if (p == 4) write_reg(CFG_UNUSED, 32'hffffffff);
                @(negedge i_clk);
            end
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            if (p == 0) begin
                ray_queue.push_back(straight_ray(0, 0));
                ray_queue.push_back(straight_ray(30000, 20000));
                ray_queue.push_back(straight_ray(-30000, 20000));
                ray_queue.push_back(straight_ray(-30000, -20000));
                ray_queue.push_back(straight_ray(30000, -20000));
                ray_queue.push_back(straight_ray(65536, 0));
                ray_queue.push_back(straight_ray(-65536, 0));
                ray_queue.push_back(straight_ray(0, -65536));
                ray_queue.push_back(straight_ray(65536, 1));
                ray_queue.push_back(straight_ray(50000, 50000));
                ray_queue.push_back(straight_ray(20000, -1));
                begin
                    t_ray_item r;
                    r = straight_ray(100, 100);
                    r.dz = 32'sd0;
                    ray_queue.push_back(r);
                    r = straight_ray(100, 100);
                    r.tlo = 32'sd131072;
                    r.thi = 32'sd0;
                    ray_queue.push_back(r);
                    r = straight_ray(100, 100);
                    r.tlo = 32'sd65536;
                    r.thi = 32'sd65536;
                    ray_queue.push_back(r);
                    r = straight_ray(100, 100);
                    r.thi = 32'sd65535;
                    ray_queue.push_back(r);
                    r = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
                    ray_queue.push_back(r);
                    r = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff};
                    ray_queue.push_back(r);
                    r = '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                          32'sh80000000, -32'sd1};
                    ray_queue.push_back(r);
                    r = '{32'sd0, 32'sd0, 32'sh80000000, 32'sd0, 32'sd0, 32'sd1,
                          32'sh80000000, 32'sh7fffffff};
                    ray_queue.push_back(r);
                    r = '{32'sd1000, 32'sd1000, 32'sd1, 32'sd7, -32'sd3, -32'sd1,
                          32'sh80000000, 32'sh7fffffff};
                    ray_queue.push_back(r);
                end
            end
            for (int n = 0; n < count_tab[p]; n++) begin
                ray_queue.push_back(random_ray());
                if (n % 40 == 39) begin
                    while (ray_queue.size() != 0) @(posedge i_clk);
                    // alternate stretches with and without idling and stalls
                    send_idle_pct = (send_idle_pct == idle_tab[p]) ? 0 : idle_tab[p];
                    recv_stall_pct = (recv_stall_pct == stall_tab[p]) ? 0 : stall_tab[p];
                end
            end
            wait_idle();
        end
        if (failures == 0) begin
            $display("ray_disk_intersect regression: pass");
        end else begin
            $display("ray_disk_intersect regression: fail");
        end
        $finish;
    end
endmodule
